// ----- design/qsu_pkg.sv -----
// ============================================================================
// qsu_pkg
// Shared types, codes and helpers for the quoted string unescape block.
// ============================================================================
package qsu_pkg;

   // Queue depth between the classify front and the result back
   localparam int QUEUE_DEPTH = 4;

   // Most result transactions one source byte can cause
   localparam int MAX_RESULTS = 3;
   localparam int IDX_W       = $clog2(MAX_RESULTS);

   // Source characters of interest
   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;

   // UTF-8 lead and continuation marks
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   // Result kind
   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // Error codes
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_NO_OPEN   = 3'd1,
      ERR_UNTERM    = 3'd2,
      ERR_NEWLINE   = 3'd3,
      ERR_ESCAPE    = 3'd4,
      ERR_HEX       = 3'd5,
      ERR_SURROGATE = 3'd6
   } err_type;

   // One classified source byte: up to three result bytes
   typedef struct packed {
      logic [IDX_W-1:0]             last_idx;
      logic [MAX_RESULTS-1:0][7:0]  data;
      kind_type                     kind;
      err_type                      err;
   } rec_type;

   // Queue status toward the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // Hex digit value, bit 4 set when the byte is not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

endpackage

// ----- design/qsu_front.sv -----
// ============================================================================
// qsu_front
// Accepts source bytes, tracks the string state and classifies each byte
// into a record of result bytes for the queue.
// ============================================================================
module qsu_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             input_done,
   output logic             rec_push,
   output qsu_pkg::rec_type rec
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_STR  = 4'b0010,
      ST_ESC  = 4'b0100,
      ST_HEX  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [11:0] code_point_ff, code_point_in;

   logic [7:0]  c;
   logic [4:0]  hv;
   logic [15:0] cp;
   logic        emit;

   assign c  = input_done ? qsu_pkg::CHAR_NUL : in_byte;
   assign hv = qsu_pkg::hex_value(c);
   assign cp = {code_point_ff, hv[3:0]};

   // Classify the byte and pick the next state
   always_comb begin
      state_in      = state_ff;
      hex_count_in  = hex_count_ff;
      code_point_in = code_point_ff;
      emit          = 1'b0;
      rec.last_idx  = '0;
      rec.data      = '0;
      rec.kind      = qsu_pkg::KIND_DATA;
      rec.err       = qsu_pkg::ERR_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (c == qsu_pkg::CHAR_QUOTE) begin
               state_in = ST_STR;
            end else begin
               emit     = 1'b1;
               rec.kind = qsu_pkg::KIND_ERROR;
               rec.err  = qsu_pkg::ERR_NO_OPEN;
            end
         end
         ST_STR: begin
            emit = 1'b1;
            if (c == qsu_pkg::CHAR_NUL) begin
               state_in = ST_IDLE;
               rec.kind = qsu_pkg::KIND_ERROR;
               rec.err  = qsu_pkg::ERR_UNTERM;
            end else if (c == qsu_pkg::CHAR_NEWLINE) begin
               state_in = ST_IDLE;
               rec.kind = qsu_pkg::KIND_ERROR;
               rec.err  = qsu_pkg::ERR_NEWLINE;
            end else if (c == qsu_pkg::CHAR_QUOTE) begin
               state_in = ST_IDLE;
               rec.kind = qsu_pkg::KIND_CLOSE;
            end else if (c == qsu_pkg::CHAR_BACKSLASH) begin
               emit     = 1'b0;
               state_in = ST_ESC;
            end else begin
               rec.data[0] = c;
            end
         end
         ST_ESC: begin
            emit     = 1'b1;
            state_in = ST_STR;
            unique case (c)
               qsu_pkg::CHAR_QUOTE:     rec.data[0] = qsu_pkg::CHAR_QUOTE;
               qsu_pkg::CHAR_BACKSLASH: rec.data[0] = qsu_pkg::CHAR_BACKSLASH;
               qsu_pkg::CHAR_LOWER_N:   rec.data[0] = qsu_pkg::CHAR_NEWLINE;
               qsu_pkg::CHAR_LOWER_T:   rec.data[0] = qsu_pkg::CHAR_TAB;
               qsu_pkg::CHAR_LOWER_R:   rec.data[0] = qsu_pkg::CHAR_CR;
               qsu_pkg::CHAR_LOWER_U: begin
                  emit          = 1'b0;
                  state_in      = ST_HEX;
                  hex_count_in  = '0;
                  code_point_in = '0;
               end
               default: begin
                  state_in = ST_IDLE;
                  rec.kind = qsu_pkg::KIND_ERROR;
                  rec.err  = qsu_pkg::ERR_ESCAPE;
               end
            endcase
         end
         ST_HEX: begin
            if (hv[4]) begin
               emit          = 1'b1;
               state_in      = ST_IDLE;
               hex_count_in  = '0;
               code_point_in = '0;
               rec.kind      = qsu_pkg::KIND_ERROR;
               rec.err       = qsu_pkg::ERR_HEX;
            end else if (hex_count_ff != 2'd3) begin
               code_point_in = {code_point_ff[7:0], hv[3:0]};
               hex_count_in  = hex_count_ff + 2'd1;
            end else begin
               emit          = 1'b1;
               hex_count_in  = '0;
               code_point_in = '0;
               if (cp[15:11] == 5'b11011) begin
                  // surrogate range
                  state_in = ST_IDLE;
                  rec.kind = qsu_pkg::KIND_ERROR;
                  rec.err  = qsu_pkg::ERR_SURROGATE;
               end else if (cp[15:7] == 9'd0) begin
                  state_in    = ST_STR;
                  rec.data[0] = cp[7:0];
               end else if (cp[15:11] == 5'd0) begin
                  state_in     = ST_STR;
                  rec.last_idx = qsu_pkg::IDX_W'(1);
                  rec.data[0]  = qsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
                  rec.data[1]  = qsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
               end else begin
                  state_in     = ST_STR;
                  rec.last_idx = qsu_pkg::IDX_W'(2);
                  rec.data[0]  = qsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
                  rec.data[1]  = qsu_pkg::UTF8_CONT | {2'b00, cp[11:6]};
                  rec.data[2]  = qsu_pkg::UTF8_CONT | {2'b00, cp[5:0]};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Errors and the end marker clear the escape state
      if (state_in == ST_IDLE) begin
         hex_count_in  = '0;
         code_point_in = '0;
      end
   end

   assign rec_push = accept && emit;

   // Advance state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hex_count_ff  <= '0;
         code_point_ff <= '0;
      end else if (accept) begin
         state_ff      <= state_in;
         hex_count_ff  <= hex_count_in;
         code_point_ff <= code_point_in;
      end
   end

endmodule

// ----- design/qsu_fifo.sv -----
// ============================================================================
// qsu_fifo
// Short record queue between the classify front and the result back.
// ============================================================================
module qsu_fifo #(
   parameter int DEPTH = qsu_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  qsu_pkg::rec_type         wr_data,
   input  logic                     rd_en,
   output qsu_pkg::rec_type         rd_data,
   output qsu_pkg::fifo_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   qsu_pkg::rec_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign rd_data      = mem_ff[rd_ptr_ff];

   // Hold record payload
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (wr_en && !rd_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (rd_en && !wr_en) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ----- design/qsu_back.sv -----
// ============================================================================
// qsu_back
// Takes records from the queue and hands out their result bytes one
// transaction at a time.
// ============================================================================
module qsu_back (
   input  logic                     clock,
   input  logic                     reset,
   input  qsu_pkg::rec_type         head,
   input  logic                     head_empty,
   output logic                     head_pop,
   input  logic                     pop,
   output logic                     empty,
   output logic [7:0]               out_byte,
   output logic [1:0]               kind,
   output logic [2:0]               error_code,
   output logic                     last
);

   logic                      valid_ff;
   qsu_pkg::rec_type          rec_ff;
   logic [qsu_pkg::IDX_W-1:0] idx_ff;
   logic                      take;

   assign empty      = !valid_ff;
   assign last       = (idx_ff == rec_ff.last_idx);
   assign kind       = rec_ff.kind;
   assign error_code = rec_ff.err;

   // Select the current byte of the record
   always_comb begin
      case (idx_ff)
         qsu_pkg::IDX_W'(0): out_byte = rec_ff.data[0];
         qsu_pkg::IDX_W'(1): out_byte = rec_ff.data[1];
         default:            out_byte = rec_ff.data[2];
      endcase
   end

   // Load a new record once the current one is drained
   assign take     = !valid_ff || (pop && last);
   assign head_pop = take && !head_empty;

   always_ff @(posedge clock) begin
      if (take) begin
         rec_ff <= head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (take) begin
         valid_ff <= !head_empty;
         idx_ff   <= '0;
      end else if (pop) begin
         idx_ff <= idx_ff + qsu_pkg::IDX_W'(1);
      end
   end

endmodule

// ----- design/quoted_string_unescape_core.sv -----
// ============================================================================
// quoted_string_unescape_core
// Decodes one double-quoted string with escapes into data bytes, an end
// marker or an error. A source byte is taken on every cycle that push is
// high and full is low, so the sustained rate is one byte per cycle; a \u
// escape that yields two or three UTF-8 bytes occupies the result side for
// that many pops, and the source side keeps going until the record queue of
// QUEUE_DEPTH entries fills. A result reaches the result ports by way of
// the record queue, which takes the record when its byte is accepted, and
// then the output register of the result side.
// Bytes that cause no result (opening quote, backslash, the u of \u, hex
// digits before the fourth) use no queue entry.
// ============================================================================
module quoted_string_unescape_core #(
   parameter int QUEUE_DEPTH = qsu_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_input_done,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last
);

   qsu_pkg::rec_type         front_rec;
   qsu_pkg::rec_type         head_rec;
   qsu_pkg::fifo_status_type fifo_st;
   logic                     front_push;
   logic                     back_pop;
   logic                     accept;

   // Stall the source when no queue entry is free
   assign full   = fifo_st.full;
   assign accept = push && !fifo_st.full;

   qsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .input_done (req_input_done),
      .rec_push   (front_push),
      .rec        (front_rec)
   );

   qsu_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_push),
      .wr_data (front_rec),
      .rd_en   (back_pop),
      .rd_data (head_rec),
      .status  (fifo_st)
   );

   qsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_rec),
      .head_empty (fifo_st.empty),
      .head_pop   (back_pop),
      .pop        (pop),
      .empty      (empty),
      .out_byte   (rsp_out_byte),
      .kind       (rsp_kind),
      .error_code (rsp_error_code),
      .last       (rsp_last)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      front_push |-> !fifo_st.full)
      else $error("record pushed into a full queue");

   a_error_code_matches_kind: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_kind == qsu_pkg::KIND_ERROR) == (rsp_error_code != qsu_pkg::ERR_NONE)))
      else $error("error code disagrees with result kind");

   a_marker_is_single: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_kind != qsu_pkg::KIND_DATA) |-> (rsp_last && rsp_out_byte == 8'h00))
      else $error("end marker or error not a lone zero-byte transaction");

   a_utf8_continues: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last) |=> (!empty && rsp_kind == qsu_pkg::KIND_DATA))
      else $error("multi-byte sequence broken");
`endif

endmodule

// ----- sim/quoted_string_unescape_core_tb.sv -----
// ============================================================================
// quoted_string_unescape_core_tb
// Self-checking bench for the quoted string unescape block. A byte-level
// decoder tracks the string state for every accepted source transaction and
// queues the data, close and error results it implies; each popped result
// transaction is checked field by field against the oldest queued one.
// Stimulus is a short directed run over escapes and every error code,
// then random strings (raw bytes, escapes, \u code points, broken tails)
// mixed with noise, with bursty pushes, patterned pops and one long pop
// hold-off that backs the block up into full.
// ============================================================================
module quoted_string_unescape_core_tb;

   typedef enum logic [1:0] {
      SCAN_IDLE   = 2'd0,
      SCAN_TEXT   = 2'd1,
      SCAN_ESCAPE = 2'd2,
      SCAN_HEX    = 2'd3
   } scan_state_type;

   typedef struct {
      logic [7:0]        out_byte;
      qsu_pkg::kind_type kind;
      qsu_pkg::err_type  err;
      logic              last;
   } result_type;

   typedef struct {
      logic [7:0] value;
      logic       done;
   } source_item_type;

   // -------------------------------------------------------------------------
   // Decoder and result scoreboard
   // -------------------------------------------------------------------------
   class unescape_checker;
      scan_state_type state;
      int             digits_seen;
      logic [15:0]    code_point;
      result_type     pending_results[$];
      int             errors;

      function new();
         state       = SCAN_IDLE;
         digits_seen = 0;
         code_point  = '0;
         errors      = 0;
      endfunction

      // Nibble value of a hex character, -1 for anything else
      static function int hex_nibble(logic [7:0] c);
         if (c >= "0" && c <= "9") begin
            return int'(c) - int'("0");
         end
         if (c >= "a" && c <= "f") begin
            return int'(c) - int'("a") + 10;
         end
         if (c >= "A" && c <= "F") begin
            return int'(c) - int'("A") + 10;
         end
         return -1;
      endfunction

      function void emit(logic [7:0] b, qsu_pkg::kind_type k, qsu_pkg::err_type e,
                         logic last);
         result_type r;
         r.out_byte = b;
         r.kind     = k;
         r.err      = e;
         r.last     = last;
         pending_results = {pending_results, r};
      endfunction

      function void go_idle();
         state       = SCAN_IDLE;
         digits_seen = 0;
         code_point  = '0;
      endfunction

      function void abort(qsu_pkg::err_type e);
         go_idle();
         emit(8'h00, qsu_pkg::KIND_ERROR, e, 1'b1);
      endfunction

      // Advance the string state by one source transaction and queue results
      function void decode_byte(logic [7:0] in_byte, logic done);
         logic [7:0]  c;
         int          nib;
         logic [15:0] cp;
         c = done ? qsu_pkg::CHAR_NUL : in_byte;
         case (state)
            SCAN_IDLE: begin
               if (c == qsu_pkg::CHAR_QUOTE) begin
                  state = SCAN_TEXT;
               end else begin
                  abort(qsu_pkg::ERR_NO_OPEN);
               end
            end
            SCAN_TEXT: begin
               if (c == qsu_pkg::CHAR_NUL) begin
                  abort(qsu_pkg::ERR_UNTERM);
               end else if (c == qsu_pkg::CHAR_NEWLINE) begin
                  abort(qsu_pkg::ERR_NEWLINE);
               end else if (c == qsu_pkg::CHAR_QUOTE) begin
                  go_idle();
                  emit(8'h00, qsu_pkg::KIND_CLOSE, qsu_pkg::ERR_NONE, 1'b1);
               end else if (c == qsu_pkg::CHAR_BACKSLASH) begin
                  state = SCAN_ESCAPE;
               end else begin
                  emit(c, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE, 1'b1);
               end
            end
            SCAN_ESCAPE: begin
               case (c)
                  qsu_pkg::CHAR_QUOTE: begin
                     state = SCAN_TEXT;
                     emit(qsu_pkg::CHAR_QUOTE, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE, 1'b1);
                  end
                  qsu_pkg::CHAR_BACKSLASH: begin
                     state = SCAN_TEXT;
                     emit(qsu_pkg::CHAR_BACKSLASH, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE,
                          1'b1);
                  end
                  qsu_pkg::CHAR_LOWER_N: begin
                     state = SCAN_TEXT;
                     emit(qsu_pkg::CHAR_NEWLINE, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE, 1'b1);
                  end
                  qsu_pkg::CHAR_LOWER_T: begin
                     state = SCAN_TEXT;
                     emit(qsu_pkg::CHAR_TAB, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE, 1'b1);
                  end
                  qsu_pkg::CHAR_LOWER_R: begin
                     state = SCAN_TEXT;
                     emit(qsu_pkg::CHAR_CR, qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE, 1'b1);
                  end
                  qsu_pkg::CHAR_LOWER_U: begin
                     state       = SCAN_HEX;
                     digits_seen = 0;
                     code_point  = '0;
                  end
                  default: begin
                     abort(qsu_pkg::ERR_ESCAPE);
                  end
               endcase
            end
            default: begin
               nib = hex_nibble(c);
               if (nib < 0) begin
                  abort(qsu_pkg::ERR_HEX);
               end else begin
                  cp = {code_point[11:0], 4'(nib)};
                  if (digits_seen != 3) begin
                     code_point  = cp;
                     digits_seen = digits_seen + 1;
                  end else if (cp >= 16'hD800 && cp <= 16'hDFFF) begin
                     abort(qsu_pkg::ERR_SURROGATE);
                  end else begin
                     state       = SCAN_TEXT;
                     digits_seen = 0;
                     code_point  = '0;
                     // Encode the code point as one to three UTF-8 bytes
                     if (cp < 16'h0080) begin
                        emit(cp[7:0], qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE, 1'b1);
                     end else if (cp < 16'h0800) begin
                        emit(qsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]},
                             qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE, 1'b0);
                        emit(qsu_pkg::UTF8_CONT | {2'b00, cp[5:0]},
                             qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE, 1'b1);
                     end else begin
                        emit(qsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]},
                             qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE, 1'b0);
                        emit(qsu_pkg::UTF8_CONT | {2'b00, cp[11:6]},
                             qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE, 1'b0);
                        emit(qsu_pkg::UTF8_CONT | {2'b00, cp[5:0]},
                             qsu_pkg::KIND_DATA, qsu_pkg::ERR_NONE, 1'b1);
                     end
                  end
               end
            end
         endcase
      endfunction

      task report(string msg);
         $display("%0t: mismatch: %s", $time, msg);
         errors++;
      endtask

      // Compare one popped result transaction with the oldest expectation
      task check_result(logic [7:0] b, logic [1:0] k, logic [2:0] e, logic last);
         result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result byte=%02h kind=%0d err=%0d last=%0b",
                             b, k, e, last));
         end else begin
            want = pending_results.pop_front();
            if (b !== want.out_byte) begin
               report($sformatf("out_byte %02h, expected %02h", b, want.out_byte));
            end
            if (k !== want.kind) begin
               report($sformatf("kind %0d, expected %0d", k, want.kind));
            end
            if (e !== want.err) begin
               report($sformatf("error_code %0d, expected %0d", e, want.err));
            end
            if (last !== want.last) begin
               report($sformatf("last %0b, expected %0b", last, want.last));
            end
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Signals and instance
   // -------------------------------------------------------------------------
   logic       clock;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_in_byte;
   logic       req_input_done;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic [2:0] rsp_error_code;
   logic       rsp_last;

   unescape_checker sb = new();
   source_item_type source_text[$];

   quoted_string_unescape_core u_top (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_in_byte    (req_in_byte),
      .req_input_done (req_input_done),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // End the run if it hangs
   initial begin
      #4000000;
      $display("quoted_string_unescape_core_tb: FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Monitor: note accepted source bytes, check accepted results
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            sb.decode_byte(req_in_byte, req_input_done);
         end
         if (pop && !empty) begin
            sb.check_result(rsp_out_byte, rsp_kind, rsp_error_code, rsp_last);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Source text building
   // -------------------------------------------------------------------------
   task automatic add_item(logic [7:0] b, logic done);
      source_item_type it;
      it.value = b;
      it.done  = done;
      source_text = {source_text, it};
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         add_item(s[i], 1'b0);
      end
   endtask

   // Emit \uXXXX with each letter digit in random case
   task automatic add_unicode(logic [15:0] cp);
      logic [3:0] n;
      add_text("\\u");
      for (int i = 3; i >= 0; i--) begin
         n = cp[i*4 +: 4];
         if (n < 10) begin
            add_item(8'h30 + 8'(n), 1'b0);
         end else if ($urandom_range(0, 1) == 1) begin
            add_item(8'h41 + 8'(n) - 8'd10, 1'b0);
         end else begin
            add_item(8'h61 + 8'(n) - 8'd10, 1'b0);
         end
      end
   endtask

   task automatic build_directed_text();
      // Non-quote and end of input while idle
      add_item(qsu_pkg::CHAR_NUL, 1'b0);
      add_item(8'hA5, 1'b1);
      // Extreme raw byte and every single-byte escape
      add_item(qsu_pkg::CHAR_QUOTE, 1'b0);
      add_item(8'hFF, 1'b0);
      add_text("\\n\\t\\r\\\"\\\\\"");
      // Raw newline, NUL and end of input inside the string
      add_text("\"\n");
      add_text("\"");
      add_item(qsu_pkg::CHAR_NUL, 1'b0);
      add_text("\"");
      add_item(8'h5A, 1'b1);
      // Unknown escape, non-hex digit, surrogate code point
      add_text("\"\\q");
      add_text("\"\\ug");
      add_text("\"\\udBfF");
   endtask

   task automatic build_random_text(int count);
      int          stop_at;
      int          elems;
      logic [7:0]  b;
      logic [15:0] cp;
      stop_at = source_text.size() + count;
      while (source_text.size() < stop_at) begin
         if ($urandom_range(0, 99) < 75) begin
            // Well-formed string with random content, sometimes broken
            add_item(qsu_pkg::CHAR_QUOTE, 1'b0);
            elems = $urandom_range(0, 8);
            for (int i = 0; i < elems; i++) begin
               case ($urandom_range(0, 3))
                  0, 1: begin
                     do b = 8'($urandom_range(1, 255));
                     while (b == qsu_pkg::CHAR_QUOTE || b == qsu_pkg::CHAR_BACKSLASH ||
                            b == qsu_pkg::CHAR_NEWLINE);
                     add_item(b, 1'b0);
                  end
                  2: begin
                     case ($urandom_range(0, 4))
                        0: add_text("\\\"");
                        1: add_text("\\\\");
                        2: add_text("\\n");
                        3: add_text("\\t");
                        default: add_text("\\r");
                     endcase
                  end
                  default: begin
                     case ($urandom_range(0, 2))
                        0: cp = 16'($urandom_range(0, 16'h007F));
                        1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        default: begin
                           if ($urandom_range(0, 1) == 1) begin
                              cp = 16'($urandom_range(16'h0800, 16'hD7FF));
                           end else begin
                              cp = 16'($urandom_range(16'hE000, 16'hFFFF));
                           end
                        end
                     endcase
                     add_unicode(cp);
                  end
               endcase
            end
            if ($urandom_range(0, 99) < 85) begin
               add_item(qsu_pkg::CHAR_QUOTE, 1'b0);
            end else begin
               // Break the string in one of the error ways
               case ($urandom_range(0, 5))
                  0: add_item(qsu_pkg::CHAR_NUL, 1'b0);
                  1: add_item(qsu_pkg::CHAR_NEWLINE, 1'b0);
                  2: add_item(8'($urandom_range(0, 255)), 1'b1);
                  3: begin
                     add_text("\\");
                     do b = 8'($urandom_range(0, 255));
                     while (b == qsu_pkg::CHAR_QUOTE || b == qsu_pkg::CHAR_BACKSLASH ||
                            b == qsu_pkg::CHAR_LOWER_N || b == qsu_pkg::CHAR_LOWER_T ||
                            b == qsu_pkg::CHAR_LOWER_R || b == qsu_pkg::CHAR_LOWER_U);
                     add_item(b, $urandom_range(0, 3) == 0);
                  end
                  4: begin
                     add_text("\\u");
                     elems = $urandom_range(0, 3);
                     for (int i = 0; i < elems; i++) begin
                        add_text("7");
                     end
                     do b = 8'($urandom_range(0, 255));
                     while (unescape_checker::hex_nibble(b) >= 0);
                     add_item(b, $urandom_range(0, 3) == 0);
                  end
                  default: add_unicode(16'($urandom_range(16'hD800, 16'hDFFF)));
               endcase
            end
         end else begin
            // Noise: arbitrary bytes and end-of-input markers
            elems = $urandom_range(1, 4);
            for (int i = 0; i < elems; i++) begin
               add_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // Push the source text in bursts with random gaps
   task automatic drive_source();
      int idx;
      int burst;
      int gap;
      idx = 0;
      while (idx < source_text.size()) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && idx < source_text.size()) begin
            push           <= 1'b1;
            req_in_byte    <= source_text[idx].value;
            req_input_done <= source_text[idx].done;
            @(posedge clock);
            while (full) @(posedge clock);
            idx++;
            burst--;
         end
         gap = $urandom_range(0, 5);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      push <= 1'b0;
   endtask

   // Pop in phases of varying stall rate, with one long hold-off
   task automatic pace_results();
      int cycle_count;
      int phase_left;
      int stall_pct;
      cycle_count = 0;
      phase_left  = 0;
      stall_pct   = 0;
      forever begin
         if (cycle_count == 150) begin
            pop <= 1'b0;
            repeat (80) @(posedge clock);
            cycle_count += 80;
         end
         if (phase_left == 0) begin
            phase_left = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 30;
               default: stall_pct = 75;
            endcase
         end
         pop <= ($urandom_range(0, 99) >= stall_pct);
         phase_left--;
         cycle_count++;
         @(posedge clock);
      end
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int guard;
      reset          <= 1'b1;
      push           <= 1'b0;
      pop            <= 1'b0;
      req_in_byte    <= 8'h00;
      req_input_done <= 1'b0;
      build_directed_text();
      build_random_text(320);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      fork
         drive_source();
         pace_results();
      join_any

      // Drain outstanding results, then watch for strays
      guard = 0;
      while (sb.pending_results.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (sb.pending_results.size() != 0) begin
         sb.report($sformatf("%0d expected results never arrived",
                             sb.pending_results.size()));
      end

      if (sb.errors == 0) begin
         $display("quoted_string_unescape_core_tb: PASS");
      end else begin
         $display("quoted_string_unescape_core_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/qsu_pkg.sv
design/qsu_front.sv
design/qsu_fifo.sv
design/qsu_back.sv
design/quoted_string_unescape_core.sv
sim/quoted_string_unescape_core_tb.sv
